// ===== sv/rsm_pkg.sv =====
// Shared constants, register codes and helpers for the SIMD restripe address map.
`timescale 1ns / 1ps

package rsm_pkg;

	localparam int SLOT_W  = 17;	// slot and destination index width
	localparam int ELEM_W  = 32;	// element field width on the ports
	localparam int CNT_W   = 17;	// element count register width
	localparam int CODE_W  = 2;	// size and width code registers
	localparam int LANE_W  = 6;	// up to 64 lanes per vector
	localparam int SHIFT_W = 3;	// log2 of lanes, 2..6
	localparam int IDX_W   = 2;	// configuration register index

	localparam int MAX_LENGTH_DEF = 65536;
	localparam int DATA_BITS_DEF  = 32;

	typedef enum logic [IDX_W-1:0] {
		REG_ELEM_SIZE  = 2'd0,
		REG_SRC_WIDTH  = 2'd1,
		REG_DST_WIDTH  = 2'd2,
		REG_ELEM_COUNT = 2'd3
	} rsm_reg_t;

	// element size codes
	localparam logic [CODE_W-1:0] ES_8  = 2'd0;
	localparam logic [CODE_W-1:0] ES_16 = 2'd1;

	// vector width codes
	localparam logic [CODE_W-1:0] VW_128 = 2'd0;
	localparam logic [CODE_W-1:0] VW_256 = 2'd1;

	// log2(lanes) = log2(vector bits) - log2(element bits); code 3 acts as the widest
	function automatic logic [SHIFT_W-1:0] lane_shift(input logic [CODE_W-1:0] vw,
		input logic [CODE_W-1:0] es);
		logic [SHIFT_W-1:0] v;
		logic [SHIFT_W-1:0] e;
		v = (vw == VW_128) ? 3'd0 : ((vw == VW_256) ? 3'd1 : 3'd2);
		e = (es == ES_8) ? 3'd0 : ((es == ES_16) ? 3'd1 : 3'd2);
		return 3'd4 + v - e;
	endfunction

	// width of a saturated element count
	function automatic int len_width(input int max_len);
		int w;
		w = $clog2(max_len + 1);
		return (w > CNT_W) ? CNT_W : w;
	endfunction

endpackage

// ===== sv/rsm_if.sv =====
// Request and result channel interfaces of the restripe address map.
`timescale 1ns / 1ps

interface rsm_req_if;
	logic                        valid;
	logic                        ready;
	logic [rsm_pkg::SLOT_W-1:0]  source_slot;
	logic [rsm_pkg::ELEM_W-1:0]  element_in;

	modport source (output valid, output source_slot, output element_in, input ready);
	modport sink (input valid, input source_slot, input element_in, output ready);
endinterface

interface rsm_res_if;
	logic                        valid;
	logic                        ready;
	logic                        write_enable;
	logic [rsm_pkg::SLOT_W-1:0]  dest_index;
	logic [rsm_pkg::ELEM_W-1:0]  element_out;

	modport source (output valid, output write_enable, output dest_index,
		output element_out, input ready);
	modport sink (input valid, input write_enable, input dest_index,
		input element_out, output ready);
endinterface

// ===== sv/rsm_front.sv =====
// Front stages: slot split, vector counts, unstriped position and range checks.
`timescale 1ns / 1ps

module rsm_front #(
	parameter int MAX_LENGTH = rsm_pkg::MAX_LENGTH_DEF,
	parameter int DATA_BITS  = rsm_pkg::DATA_BITS_DEF,
	parameter int LW         = rsm_pkg::len_width(MAX_LENGTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rsm_pkg::CODE_W-1:0]    esize,
	input  logic [rsm_pkg::CODE_W-1:0]    swidth,
	input  logic [rsm_pkg::CODE_W-1:0]    dwidth,
	input  logic [rsm_pkg::CNT_W-1:0]     count,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  logic [rsm_pkg::SLOT_W-1:0]    slot,
	input  logic [rsm_pkg::ELEM_W-1:0]    elem,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output logic [LW-1:0]                 pos,
	output logic [LW-1:0]                 qd,
	output logic [rsm_pkg::SHIFT_W-1:0]   dl,
	output logic                          hit,
	output logic [DATA_BITS-1:0]          data
);

	localparam int PW = LW + rsm_pkg::LANE_W + 1;

	// max(2, ceil(len / 2^sh))
	function automatic logic [LW-1:0] vec_count(input logic [LW-1:0] len,
		input logic [rsm_pkg::SHIFT_W-1:0] sh);
		logic [LW-1:0] q;
		q = ((len - 1'b1) >> sh) + 1'b1;
		if (len == '0) q = LW'(1);
		if (q < LW'(2)) q = LW'(2);
		return q;
	endfunction

	logic [rsm_pkg::SHIFT_W-1:0] sl;
	logic [rsm_pkg::SHIFT_W-1:0] dl_c;
	logic [LW-1:0]               len_c;
	logic [rsm_pkg::SLOT_W-1:0]  vec_full;
	logic [rsm_pkg::LANE_W-1:0]  lane_c;
	logic [LW-1:0]               qs_c;
	logic [rsm_pkg::ELEM_W-1:0]  emask;

	logic                        vld_s1;
	logic [LW-1:0]               vec_s1;
	logic [rsm_pkg::LANE_W-1:0]  lane_s1;
	logic [LW-1:0]               qs_s1;
	logic [LW-1:0]               qd_s1;
	logic [LW-1:0]               len_s1;
	logic [rsm_pkg::SHIFT_W-1:0] dl_s1;
	logic                        inb_s1;
	logic [DATA_BITS-1:0]        data_s1;

	logic [PW-1:0]               pos_full;

	logic                        vld_s2;
	logic [LW-1:0]               pos_s2;
	logic [LW-1:0]               qd_s2;
	logic [rsm_pkg::SHIFT_W-1:0] dl_s2;
	logic                        hit_s2;
	logic [DATA_BITS-1:0]        data_s2;

	logic rdy_s1;
	logic rdy_s2;

	assign rdy_s2   = !vld_s2 || dn_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	// stage 1: decode codes, saturate count, split slot
	always_comb begin
		sl       = rsm_pkg::lane_shift(swidth, esize);
		dl_c     = rsm_pkg::lane_shift(dwidth, esize);
		len_c    = (32'(count) > 32'(MAX_LENGTH)) ? LW'(MAX_LENGTH) : LW'(count);
		qs_c     = vec_count(len_c, sl);
		vec_full = slot >> sl;
		lane_c   = slot[rsm_pkg::LANE_W-1:0] & ~(6'h3F << sl);
		case (esize)
			rsm_pkg::ES_8:  emask = 32'h0000_00FF;
			rsm_pkg::ES_16: emask = 32'h0000_FFFF;
			default:        emask = 32'hFFFF_FFFF;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			vec_s1  <= LW'(vec_full);
			lane_s1 <= lane_c;
			qs_s1   <= qs_c;
			qd_s1   <= vec_count(len_c, dl_c);
			len_s1  <= len_c;
			dl_s1   <= dl_c;
			inb_s1  <= vec_full < rsm_pkg::SLOT_W'(qs_c);
			data_s1 <= DATA_BITS'(elem & emask);
		end
	end

	// stage 2: pos = lane * qs + vec, padding check
	assign pos_full = PW'(lane_s1) * PW'(qs_s1) + PW'(vec_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			pos_s2  <= LW'(pos_full);
			qd_s2   <= qd_s1;
			dl_s2   <= dl_s1;
			hit_s2  <= inb_s1 && (pos_full < PW'(len_s1));
			data_s2 <= data_s1;
		end
	end

	assign dn_valid = vld_s2;
	assign pos      = pos_s2;
	assign qd       = qd_s2;
	assign dl       = dl_s2;
	assign hit      = hit_s2;
	assign data     = data_s2;

endmodule

// ===== sv/rsm_div_stage.sv =====
// One stage of the restoring divider: STEPS quotient bits of pos / qd per cycle while not stalled.
`timescale 1ns / 1ps

module rsm_div_stage #(
	parameter int LW        = 17,
	parameter int STEPS     = 2,
	parameter int DATA_BITS = rsm_pkg::DATA_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  logic [LW-1:0]                 num_in,
	input  logic [LW-1:0]                 rem_in,
	input  logic [LW-1:0]                 quot_in,
	input  logic [LW-1:0]                 qd_in,
	input  logic [rsm_pkg::SHIFT_W-1:0]   dl_in,
	input  logic                          hit_in,
	input  logic [DATA_BITS-1:0]          data_in,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output logic [LW-1:0]                 num_out,
	output logic [LW-1:0]                 rem_out,
	output logic [LW-1:0]                 quot_out,
	output logic [LW-1:0]                 qd_out,
	output logic [rsm_pkg::SHIFT_W-1:0]   dl_out,
	output logic                          hit_out,
	output logic [DATA_BITS-1:0]          data_out
);

	logic [LW-1:0] num_c;
	logic [LW-1:0] rem_c;
	logic [LW-1:0] quot_c;
	logic [LW:0]   trial;
	logic          qbit;

	logic                        vld_q;
	logic [LW-1:0]               num_q;
	logic [LW-1:0]               rem_q;
	logic [LW-1:0]               quot_q;
	logic [LW-1:0]               qd_q;
	logic [rsm_pkg::SHIFT_W-1:0] dl_q;
	logic                        hit_q;
	logic [DATA_BITS-1:0]        data_q;

	assign up_ready = !vld_q || dn_ready;

	// shift one dividend bit into the remainder, subtract when it fits
	always_comb begin
		num_c  = num_in;
		rem_c  = rem_in;
		quot_c = quot_in;
		trial  = '0;
		qbit   = 1'b0;
		for (int i = 0; i < STEPS; i++) begin
			trial = {rem_c, num_c[LW-1]};
			qbit  = trial >= {1'b0, qd_in};
			if (qbit) trial = trial - {1'b0, qd_in};
			rem_c  = trial[LW-1:0];
			quot_c = {quot_c[LW-2:0], qbit};
			num_c  = num_c << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			num_q  <= num_c;
			rem_q  <= rem_c;
			quot_q <= quot_c;
			qd_q   <= qd_in;
			dl_q   <= dl_in;
			hit_q  <= hit_in;
			data_q <= data_in;
		end
	end

	assign dn_valid = vld_q;
	assign num_out  = num_q;
	assign rem_out  = rem_q;
	assign quot_out = quot_q;
	assign qd_out   = qd_q;
	assign dl_out   = dl_q;
	assign hit_out  = hit_q;
	assign data_out = data_q;

endmodule

// ===== sv/simd_restripe_address_map_unit.sv =====
// Top level of the SIMD restripe address map: config registers, pipeline and output register.
`timescale 1ns / 1ps

// Maps each slot of a buffer striped for one SIMD width to its slot in the striping
// for another width, passing the element through masked to its size. Lanes per
// vector are a power of two set by the element size and vector width codes, so the
// source split is a shift and mask; the destination vector count is any value from
// two up, so the final pos mod / div is a restoring divider spread over pipeline
// stages, two quotient bits per stage (one in the last when LW is odd), where LW =
// min(17, clog2(MAX_LENGTH + 1)). One request is taken every clock when the result
// side keeps up. Every stage has its own valid bit and stalls only when the stage
// after it is full, so bubbles are squeezed out and the request side keeps accepting
// while a finished result waits. Slots past the source buffer and padding lanes give
// a result with write_enable low and zero index and data. Registers are written
// through cfg_we / cfg_index / cfg_data; the user must do so only while no request
// is in flight, which the block itself does not enforce.
module simd_restripe_address_map_unit #(
	parameter int MAX_LENGTH = rsm_pkg::MAX_LENGTH_DEF,
	parameter int DATA_BITS  = rsm_pkg::DATA_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rsm_pkg::IDX_W-1:0]   cfg_index,
	input  logic [rsm_pkg::CNT_W-1:0]   cfg_data,
	rsm_req_if.sink                     req,
	rsm_res_if.source                   res
);

	localparam int LW   = rsm_pkg::len_width(MAX_LENGTH);
	localparam int NSTG = (LW + 1) / 2;	// divider stages
	localparam int DXW  = LW + rsm_pkg::LANE_W + 1;

	// configuration registers
	logic [rsm_pkg::CODE_W-1:0] esize_q;
	logic [rsm_pkg::CODE_W-1:0] swidth_q;
	logic [rsm_pkg::CODE_W-1:0] dwidth_q;
	logic [rsm_pkg::CNT_W-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esize_q  <= '0;
			swidth_q <= '0;
			dwidth_q <= '0;
			count_q  <= '0;
		end else if (cfg_we) begin
			case (rsm_pkg::rsm_reg_t'(cfg_index))
				rsm_pkg::REG_ELEM_SIZE:  esize_q  <= cfg_data[rsm_pkg::CODE_W-1:0];
				rsm_pkg::REG_SRC_WIDTH:  swidth_q <= cfg_data[rsm_pkg::CODE_W-1:0];
				rsm_pkg::REG_DST_WIDTH:  dwidth_q <= cfg_data[rsm_pkg::CODE_W-1:0];
				rsm_pkg::REG_ELEM_COUNT: count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// divider chain, index k feeds stage k
	logic                        div_vld  [NSTG+1];
	logic                        div_rdy  [NSTG+1];
	logic [LW-1:0]               div_num  [NSTG+1];
	logic [LW-1:0]               div_rem  [NSTG+1];
	logic [LW-1:0]               div_quot [NSTG+1];
	logic [LW-1:0]               div_qd   [NSTG+1];
	logic [rsm_pkg::SHIFT_W-1:0] div_dl   [NSTG+1];
	logic                        div_hit  [NSTG+1];
	logic [DATA_BITS-1:0]        div_data [NSTG+1];

	assign div_rem[0]  = '0;
	assign div_quot[0] = '0;

	// stages 1 and 2: slot split, position and range checks
	rsm_front #(
		.MAX_LENGTH(MAX_LENGTH),
		.DATA_BITS (DATA_BITS),
		.LW        (LW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.esize    (esize_q),
		.swidth   (swidth_q),
		.dwidth   (dwidth_q),
		.count    (count_q),
		.up_valid (req.valid),
		.up_ready (req.ready),
		.slot     (req.source_slot),
		.elem     (req.element_in),
		.dn_valid (div_vld[0]),
		.dn_ready (div_rdy[0]),
		.pos      (div_num[0]),
		.qd       (div_qd[0]),
		.dl       (div_dl[0]),
		.hit      (div_hit[0]),
		.data     (div_data[0])
	);

	// pos / qd, MSB first; the last stage takes one bit when LW is odd
	for (genvar k = 0; k < NSTG; k++) begin : g_div
		localparam int ST = ((LW - 2 * k) >= 2) ? 2 : 1;

		rsm_div_stage #(
			.LW       (LW),
			.STEPS    (ST),
			.DATA_BITS(DATA_BITS)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (div_vld[k]),
			.up_ready (div_rdy[k]),
			.num_in   (div_num[k]),
			.rem_in   (div_rem[k]),
			.quot_in  (div_quot[k]),
			.qd_in    (div_qd[k]),
			.dl_in    (div_dl[k]),
			.hit_in   (div_hit[k]),
			.data_in  (div_data[k]),
			.dn_valid (div_vld[k+1]),
			.dn_ready (div_rdy[k+1]),
			.num_out  (div_num[k+1]),
			.rem_out  (div_rem[k+1]),
			.quot_out (div_quot[k+1]),
			.qd_out   (div_qd[k+1]),
			.dl_out   (div_dl[k+1]),
			.hit_out  (div_hit[k+1]),
			.data_out (div_data[k+1])
		);
	end

	// destination slot = (pos mod qd) * lanes + pos / qd; quotient is below lanes
	logic [DXW-1:0] dest_x;
	assign dest_x = (DXW'(div_rem[NSTG]) << div_dl[NSTG]) + DXW'(div_quot[NSTG]);

	// result register
	logic                        ovld_q;
	logic                        we_q;
	logic [rsm_pkg::SLOT_W-1:0]  dest_q;
	logic [DATA_BITS-1:0]        data_q;
	logic                        rdy_o;

	assign rdy_o         = !ovld_q || res.ready;
	assign div_rdy[NSTG] = rdy_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (rdy_o) begin
			ovld_q <= div_vld[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && div_vld[NSTG]) begin
			we_q   <= div_hit[NSTG];
			dest_q <= div_hit[NSTG] ? rsm_pkg::SLOT_W'(dest_x) : '0;
			data_q <= div_hit[NSTG] ? div_data[NSTG] : '0;
		end
	end

	assign res.valid        = ovld_q;
	assign res.write_enable = we_q;
	assign res.dest_index   = dest_q;
	assign res.element_out  = rsm_pkg::ELEM_W'(data_q);

	// request side only blocks when every stage is full and the result is held
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> (res.valid && !res.ready))
		else $error("request stalled while pipeline has room");

	// a skipped slot never carries index or data
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.write_enable) |-> (res.dest_index == '0 && res.element_out == '0))
		else $error("skipped slot with nonzero payload");

	// byte elements leave the upper bits clear
	a_byte_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.write_enable && esize_q == rsm_pkg::ES_8)
		|-> (res.element_out[31:8] == '0))
		else $error("byte element wider than its size");

	// pos / qd fits in the lane field of the destination slot
	a_quot_lane: assert property (@(posedge clk) disable iff (!arst_n)
		(div_vld[NSTG] && div_hit[NSTG])
		|-> ((DXW'(div_quot[NSTG]) >> div_dl[NSTG]) == '0))
		else $error("quotient overflows destination lane");

endmodule
